// File: rtl/ghsm_pkg.sv
// ----------------------------------------------------------------------------
// ghsm_pkg
// Shared codes, write-enable group and helpers for the generational slot map.
// ----------------------------------------------------------------------------
package ghsm_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [2:0] FN_SPAWN   = 3'd0;
    localparam logic [2:0] FN_DESTROY = 3'd1;
    localparam logic [2:0] FN_CLEAR   = 3'd2;
    localparam logic [2:0] FN_LOOKUP  = 3'd3;
    localparam logic [2:0] FN_READ    = 3'd4;

    // Result status codes.
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_BAD_MESH = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_BAD_HNDL = 3'd3;
    localparam logic [2:0] STS_BAD_POS  = 3'd4;

    localparam int IN_W  = 112;
    localparam int OUT_W = 128;

    // Per-field write enables of the slot table.
    typedef struct packed {
        logic gen;
        logic alive;
        logic dpos;
        logic nxt;
    } slot_we_t;

    // Generation increment that skips zero.
    function automatic logic [15:0] gen_bump(input logic [15:0] g);
        logic [15:0] n;
        n = g + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    function automatic logic [OUT_W-1:0] pack_result(
        input logic        ok,
        input logic [2:0]  status,
        input logic [31:0] hndl,
        input logic [9:0]  dense,
        input logic [31:0] mesh,
        input logic [31:0] mat,
        input logic [10:0] live
    );
        return {7'd0, live, mat, mesh, dense, hndl, status, ok};
    endfunction

endpackage

// File: rtl/ghsm_slot_mem.sv
// ----------------------------------------------------------------------------
// ghsm_slot_mem
// Slot table: generation, alive flag, dense position and free-list link.
// ----------------------------------------------------------------------------
module ghsm_slot_mem #(
    parameter int MAX_ENTRIES = 1024,
    parameter int SW          = 10,
    parameter int CW          = 11
) (
    input  logic                clk,
    input  logic [SW-1:0]       raddr,
    output logic [15:0]         rd_gen,
    output logic                rd_alive,
    output logic [SW-1:0]       rd_dpos,
    output logic [CW-1:0]       rd_nxt,
    input  ghsm_pkg::slot_we_t  we,
    input  logic [SW-1:0]       waddr,
    input  logic [SW-1:0]       dpos_waddr,
    input  logic [15:0]         wr_gen,
    input  logic                wr_alive,
    input  logic [SW-1:0]       wr_dpos,
    input  logic [CW-1:0]       wr_nxt
);

    logic [15:0]   gen_mem   [MAX_ENTRIES];
    logic          alive_mem [MAX_ENTRIES];
    logic [SW-1:0] dpos_mem  [MAX_ENTRIES];
    logic [CW-1:0] nxt_mem   [MAX_ENTRIES];

    always_ff @(posedge clk) begin
        if (we.gen)   gen_mem[waddr]        <= wr_gen;
        if (we.alive) alive_mem[waddr]      <= wr_alive;
        if (we.dpos)  dpos_mem[dpos_waddr]  <= wr_dpos;
        if (we.nxt)   nxt_mem[waddr]        <= wr_nxt;
        rd_gen   <= gen_mem[raddr];
        rd_alive <= alive_mem[raddr];
        rd_dpos  <= dpos_mem[raddr];
        rd_nxt   <= nxt_mem[raddr];
    end

endmodule

// File: rtl/ghsm_dense_mem.sv
// ----------------------------------------------------------------------------
// ghsm_dense_mem
// Packed record array: owning slot, mesh id and material id.
// ----------------------------------------------------------------------------
module ghsm_dense_mem #(
    parameter int MAX_ENTRIES = 1024,
    parameter int SW          = 10
) (
    input  logic          clk,
    input  logic [SW-1:0] raddr,
    output logic [SW-1:0] rd_slot,
    output logic [31:0]   rd_mesh,
    output logic [31:0]   rd_mat,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  logic [SW-1:0] wr_slot,
    input  logic [31:0]   wr_mesh,
    input  logic [31:0]   wr_mat
);

    logic [SW-1:0] slot_mem [MAX_ENTRIES];
    logic [31:0]   mesh_mem [MAX_ENTRIES];
    logic [31:0]   mat_mem  [MAX_ENTRIES];

    always_ff @(posedge clk) begin
        if (we) begin
            slot_mem[waddr] <= wr_slot;
            mesh_mem[waddr] <= wr_mesh;
            mat_mem[waddr]  <= wr_mat;
        end
        rd_slot <= slot_mem[raddr];
        rd_mesh <= mesh_mem[raddr];
        rd_mat  <= mat_mem[raddr];
    end

endmodule

// File: rtl/generational_handle_slot_map_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_map_unit
// Slot map with generation-checked handles over a slot table and a packed
// record array, both synchronous memories with registered read data.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Ports                        Word contents (lowest bit first)
// -------  ---  ---------------------------  ---------------------------------
// input    in   s_tvalid s_tready s_tdata     handle, mesh_id, material_id,
//                        s_tuser              dense_pos; s_tuser = func
// result   out  m_tvalid m_tready m_tdata     ok, status, out_handle, entity_pos,
//                                             out_mesh, out_material,
//                                             live_entries
//
// One word is processed at a time. Failed decode checks and unknown operations
// go straight to the result; spawn reads the free-list head, then writes; lookup
// reads the slot, then the record; destroy also moves the last record into
// the hole; read reads the record, then its owner's slot. The result word
// turns valid as the unit returns to idle. Each step is one read of a memory
// whose data returns the next cycle. Clear walks the slot table one entry per cycle.
// After reset the same walk initializes the slot table while s_tready stays
// low. A finished result sits in the output register; the unit accepts the
// next word while it waits and only stalls when a second result is ready
// before the first is taken.
module generational_handle_slot_map_unit #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // handle[31:0], mesh_id[63:32], material_id[95:64], dense_pos[105:96]
    input  logic [ghsm_pkg::IN_W-1:0]  s_tdata,
    // func[2:0]
    input  logic [2:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // ok[0], status[3:1], out_handle[35:4], entity_pos[45:36], out_mesh[77:46],
    // out_material[109:78], live_entries[120:110]
    output logic [ghsm_pkg::OUT_W-1:0] m_tdata
);

    localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] NONE_IDX = CW'(MAX_ENTRIES);
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_ENTRIES - 1);
    localparam logic [16:0]   MAX_W    = 17'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SWEEP, ST_SPAWN, ST_HCHK,
        ST_DCHK, ST_MOVE, ST_RGEN, ST_ROUT, ST_RESULT
    } state_t;

    state_t state_reg;
    logic   init_reg;

    // Latched input word.
    logic [2:0]  func_reg;
    logic [31:0] handle_reg;
    logic [31:0] mesh_reg;
    logic [31:0] mat_reg;
    logic [9:0]  pos_reg;

    // Map bookkeeping.
    logic [CW-1:0] head_reg;
    logic [CW-1:0] live_reg;

    // Working registers.
    logic [SW-1:0] hslot_reg;
    logic [15:0]   gen_reg;
    logic [SW-1:0] dpos_reg;
    logic [SW-1:0] idx_reg;
    logic [31:0]   smesh_reg;
    logic [31:0]   smat_reg;
    logic [ghsm_pkg::OUT_W-1:0] res_reg;
    logic                       m_tvalid_reg;
    logic [ghsm_pkg::OUT_W-1:0] m_tdata_reg;

    // Memory ports.
    logic [SW-1:0]      slot_raddr;
    logic [15:0]        slot_rd_gen;
    logic               slot_rd_alive;
    logic [SW-1:0]      slot_rd_dpos;
    logic [CW-1:0]      slot_rd_nxt;
    ghsm_pkg::slot_we_t slot_we;
    logic [SW-1:0]      slot_waddr;
    logic [SW-1:0]      dpos_waddr;
    logic [15:0]        slot_wr_gen;
    logic               slot_wr_alive;
    logic [SW-1:0]      slot_wr_dpos;
    logic [CW-1:0]      slot_wr_nxt;

    logic [SW-1:0] dense_raddr;
    logic [SW-1:0] dense_rd_slot;
    logic [31:0]   dense_rd_mesh;
    logic [31:0]   dense_rd_mat;
    logic          dense_we;
    logic [SW-1:0] dense_waddr;
    logic [SW-1:0] dense_wr_slot;
    logic [31:0]   dense_wr_mesh;
    logic [31:0]   dense_wr_mat;

    // Decoded handle and derived positions.
    logic [16:0]   hslot_w;
    logic          hndl_bad;
    logic          pos_bad;
    logic [SW-1:0] last_pos;
    logic [10:0]   live_out;

    assign hslot_w  = {1'b0, handle_reg[15:0]} - 17'd1;
    assign hndl_bad = (handle_reg[15:0] == 16'd0) || (hslot_w >= MAX_W);
    assign pos_bad  = (17'(pos_reg) >= 17'(live_reg)) || (17'(pos_reg) >= MAX_W);
    assign last_pos = SW'(live_reg - CW'(1));
    assign live_out = 11'(live_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ghsm_slot_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SW          (SW),
        .CW          (CW)
    ) u_slot (
        .clk        (aclk),
        .raddr      (slot_raddr),
        .rd_gen     (slot_rd_gen),
        .rd_alive   (slot_rd_alive),
        .rd_dpos    (slot_rd_dpos),
        .rd_nxt     (slot_rd_nxt),
        .we         (slot_we),
        .waddr      (slot_waddr),
        .dpos_waddr (dpos_waddr),
        .wr_gen     (slot_wr_gen),
        .wr_alive   (slot_wr_alive),
        .wr_dpos    (slot_wr_dpos),
        .wr_nxt     (slot_wr_nxt)
    );

    ghsm_dense_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SW          (SW)
    ) u_dense (
        .clk     (aclk),
        .raddr   (dense_raddr),
        .rd_slot (dense_rd_slot),
        .rd_mesh (dense_rd_mesh),
        .rd_mat  (dense_rd_mat),
        .we      (dense_we),
        .waddr   (dense_waddr),
        .wr_slot (dense_wr_slot),
        .wr_mesh (dense_wr_mesh),
        .wr_mat  (dense_wr_mat)
    );

    // Memory addressing and write data for each step.
    always_comb begin
        slot_raddr    = '0;
        slot_we       = '0;
        slot_waddr    = hslot_reg;
        dpos_waddr    = hslot_reg;
        slot_wr_gen   = gen_reg;
        slot_wr_alive = 1'b0;
        slot_wr_dpos  = '0;
        slot_wr_nxt   = head_reg;
        dense_raddr   = '0;
        dense_we      = 1'b0;
        dense_waddr   = dpos_reg;
        dense_wr_slot = dense_rd_slot;
        dense_wr_mesh = dense_rd_mesh;
        dense_wr_mat  = dense_rd_mat;
        unique case (state_reg)
            ST_DECODE: begin
                if (func_reg == ghsm_pkg::FN_SPAWN) begin
                    slot_raddr = head_reg[SW-1:0];
                end else if (func_reg == ghsm_pkg::FN_READ) begin
                    dense_raddr = SW'(pos_reg);
                end else begin
                    slot_raddr = hslot_w[SW-1:0];
                end
                if (func_reg == ghsm_pkg::FN_CLEAR) begin
                    slot_raddr = '0;
                end
            end
            ST_SWEEP: begin
                slot_we       = '1;
                slot_waddr    = idx_reg;
                dpos_waddr    = idx_reg;
                slot_wr_gen   = init_reg ? 16'd1 : ghsm_pkg::gen_bump(slot_rd_gen);
                slot_wr_alive = 1'b0;
                slot_wr_dpos  = '0;
                slot_wr_nxt   = CW'(idx_reg) + CW'(1);
                slot_raddr    = (idx_reg == LAST_IDX) ? '0 : idx_reg + SW'(1);
            end
            ST_SPAWN: begin
                slot_we.alive = 1'b1;
                slot_we.dpos  = 1'b1;
                slot_we.nxt   = 1'b1;
                slot_waddr    = head_reg[SW-1:0];
                dpos_waddr    = head_reg[SW-1:0];
                slot_wr_alive = 1'b1;
                slot_wr_dpos  = SW'(live_reg);
                slot_wr_nxt   = NONE_IDX;
                dense_we      = 1'b1;
                dense_waddr   = SW'(live_reg);
                dense_wr_slot = head_reg[SW-1:0];
                dense_wr_mesh = mesh_reg;
                dense_wr_mat  = mat_reg;
            end
            ST_HCHK: begin
                dense_raddr = slot_rd_dpos;
            end
            ST_DCHK: begin
                dense_raddr = last_pos;
            end
            ST_MOVE: begin
                // Retire the slot; the dead slot's dense position is never read.
                slot_we.gen   = 1'b1;
                slot_we.alive = 1'b1;
                slot_we.nxt   = 1'b1;
                slot_wr_gen   = ghsm_pkg::gen_bump(gen_reg);
                slot_wr_nxt   = head_reg;
                if (dpos_reg != last_pos) begin
                    // Last record fills the hole; its owner learns the new place.
                    dense_we     = 1'b1;
                    slot_we.dpos = 1'b1;
                    dpos_waddr   = dense_rd_slot;
                    slot_wr_dpos = dpos_reg;
                end
            end
            ST_RGEN: begin
                slot_raddr = dense_rd_slot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            init_reg     <= 1'b1;
            idx_reg      <= '0;
            head_reg     <= '0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The result state handles the output register on its own.
            if (m_tvalid_reg && m_tready && state_reg != ST_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg   <= s_tuser;
                        handle_reg <= s_tdata[31:0];
                        mesh_reg   <= s_tdata[63:32];
                        mat_reg    <= s_tdata[95:64];
                        pos_reg    <= s_tdata[105:96];
                        state_reg  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    hslot_reg <= hslot_w[SW-1:0];
                    state_reg <= ST_RESULT;
                    unique case (func_reg) inside
                        ghsm_pkg::FN_SPAWN: begin
                            if (mesh_reg == 32'd0) begin
                                res_reg <= ghsm_pkg::pack_result(1'b0,
                                    ghsm_pkg::STS_BAD_MESH, '0, '0, '0, '0, live_out);
                            end else if (live_reg >= CW'(MAX_ENTRIES) ||
                                         head_reg >= CW'(MAX_ENTRIES)) begin
                                res_reg <= ghsm_pkg::pack_result(1'b0,
                                    ghsm_pkg::STS_FULL, '0, '0, '0, '0, live_out);
                            end else begin
                                state_reg <= ST_SPAWN;
                            end
                        end
                        ghsm_pkg::FN_DESTROY, ghsm_pkg::FN_LOOKUP: begin
                            if (hndl_bad) begin
                                res_reg <= ghsm_pkg::pack_result(1'b0,
                                    ghsm_pkg::STS_BAD_HNDL, '0, '0, '0, '0, live_out);
                            end else begin
                                state_reg <= ST_HCHK;
                            end
                        end
                        ghsm_pkg::FN_CLEAR: begin
                            idx_reg   <= '0;
                            state_reg <= ST_SWEEP;
                        end
                        ghsm_pkg::FN_READ: begin
                            if (pos_bad) begin
                                res_reg <= ghsm_pkg::pack_result(1'b0,
                                    ghsm_pkg::STS_BAD_POS, '0, '0, '0, '0, live_out);
                            end else begin
                                state_reg <= ST_RGEN;
                            end
                        end
                        default: begin
                            res_reg <= ghsm_pkg::pack_result(1'b0,
                                ghsm_pkg::STS_OK, '0, '0, '0, '0, live_out);
                        end
                    endcase
                end
                ST_SWEEP: begin
                    idx_reg <= idx_reg + SW'(1);
                    if (idx_reg == LAST_IDX) begin
                        head_reg <= '0;
                        live_reg <= '0;
                        init_reg <= 1'b0;
                        res_reg  <= ghsm_pkg::pack_result(1'b1,
                            ghsm_pkg::STS_OK, '0, '0, '0, '0, 11'd0);
                        state_reg <= init_reg ? ST_IDLE : ST_RESULT;
                    end
                end
                ST_SPAWN: begin
                    head_reg  <= slot_rd_nxt;
                    live_reg  <= live_reg + CW'(1);
                    res_reg   <= ghsm_pkg::pack_result(1'b1, ghsm_pkg::STS_OK,
                        {slot_rd_gen, 16'(17'(head_reg[SW-1:0]) + 17'd1)},
                        10'(live_reg), mesh_reg, mat_reg, 11'(live_reg + CW'(1)));
                    state_reg <= ST_RESULT;
                end
                ST_HCHK: begin
                    gen_reg  <= slot_rd_gen;
                    dpos_reg <= slot_rd_dpos;
                    if (slot_rd_alive && slot_rd_gen == handle_reg[31:16] &&
                        17'(slot_rd_dpos) < 17'(live_reg)) begin
                        state_reg <= ST_DCHK;
                    end else begin
                        res_reg <= ghsm_pkg::pack_result(1'b0,
                            ghsm_pkg::STS_BAD_HNDL, '0, '0, '0, '0, live_out);
                        state_reg <= ST_RESULT;
                    end
                end
                ST_DCHK: begin
                    smesh_reg <= dense_rd_mesh;
                    smat_reg  <= dense_rd_mat;
                    state_reg <= ST_RESULT;
                    if (dense_rd_slot != hslot_reg) begin
                        res_reg <= ghsm_pkg::pack_result(1'b0,
                            ghsm_pkg::STS_BAD_HNDL, '0, '0, '0, '0, live_out);
                    end else if (func_reg == ghsm_pkg::FN_LOOKUP) begin
                        res_reg <= ghsm_pkg::pack_result(1'b1, ghsm_pkg::STS_OK,
                            handle_reg, 10'(dpos_reg), dense_rd_mesh, dense_rd_mat,
                            live_out);
                    end else begin
                        state_reg <= ST_MOVE;
                    end
                end
                ST_MOVE: begin
                    head_reg  <= CW'(hslot_reg);
                    live_reg  <= live_reg - CW'(1);
                    res_reg   <= ghsm_pkg::pack_result(1'b1, ghsm_pkg::STS_OK, '0,
                        10'(dpos_reg), smesh_reg, smat_reg, 11'(live_reg - CW'(1)));
                    state_reg <= ST_RESULT;
                end
                ST_RGEN: begin
                    hslot_reg <= dense_rd_slot;
                    smesh_reg <= dense_rd_mesh;
                    smat_reg  <= dense_rd_mat;
                    state_reg <= ST_ROUT;
                end
                ST_ROUT: begin
                    res_reg <= ghsm_pkg::pack_result(1'b1, ghsm_pkg::STS_OK,
                        {slot_rd_gen, 16'(17'(hslot_reg) + 17'd1)}, pos_reg,
                        smesh_reg, smat_reg, live_out);
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The live count never exceeds the table size.
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(MAX_ENTRIES))
        else $error("live count above table size");

    // A successful result always carries the ok status.
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[3:1] == ghsm_pkg::STS_OK)
        else $error("ok result with error status");

    // One word at a time: after an accept the input side closes.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // A spawn never proceeds from an empty free list.
    a_spawn_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SPAWN |-> head_reg < CW'(MAX_ENTRIES))
        else $error("spawn with empty free list");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the generational slot map. A behavioral copy of the
// slot table, free list and packed record array predicts every result word;
// directed and random operation streams run against it with random idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSLOT = 1024;
    localparam int NONE  = NSLOT;

    // Laid out like m_tdata: ok in the lowest bit.
    typedef struct packed {
        logic [10:0] live;
        logic [31:0] mat;
        logic [31:0] mesh;
        logic [9:0]  dense;
        logic [31:0] hndl;
        logic [2:0]  status;
        logic        ok;
    } slot_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [ghsm_pkg::IN_W-1:0]    s_tdata = '0;
    logic [2:0]                   s_tuser = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [ghsm_pkg::OUT_W-1:0]   m_tdata;

    always #4 aclk = ~aclk;

    generational_handle_slot_map_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow copy of the map state.
    logic [15:0] sh_gen [NSLOT];
    logic        sh_alive [NSLOT];
    int          sh_dpos [NSLOT];
    int          sh_next [NSLOT];
    int          sh_dslot [NSLOT];
    logic [31:0] sh_dmesh [NSLOT];
    logic [31:0] sh_dmat [NSLOT];
    int          sh_head;
    int          sh_live;

    slot_result_t pending_results[$];
    logic [31:0]  known_handles[$];   // handles handed out, live or stale
    int           mismatches = 0;
    bit           hold_off = 1'b0;    // receiver forced stall request
    bit           stall_busy = 1'b0;  // long stall in progress

    function automatic logic [15:0] next_gen(logic [15:0] g);
        logic [15:0] n;
        n = g + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    function automatic void free_all();
        for (int i = 0; i < NSLOT; i++) begin
            sh_alive[i] = 1'b0;
            sh_dpos[i]  = 0;
            sh_next[i]  = i + 1;
        end
        sh_head = 0;
        sh_live = 0;
    endfunction

    function automatic bit resolve_handle(logic [31:0] h, output int slot, output int dp);
        int low;
        low = h[15:0];
        slot = 0;
        dp = 0;
        if (low == 0 || low - 1 >= NSLOT) return 0;
        slot = low - 1;
        if (!sh_alive[slot] || sh_gen[slot] != h[31:16]) return 0;
        dp = sh_dpos[slot];
        if (dp >= sh_live || sh_dslot[dp] != slot) return 0;
        return 1;
    endfunction

    // Applies one operation to the shadow state and returns the expected word.
    function automatic slot_result_t predict_op(logic [2:0] fn, logic [31:0] h,
                                                logic [31:0] mesh, logic [31:0] mat,
                                                logic [9:0] pos);
        slot_result_t r;
        int slot, dp, last, moved;
        r = '0;
        case (fn)
            ghsm_pkg::FN_SPAWN: begin
                if (mesh == 0) r.status = ghsm_pkg::STS_BAD_MESH;
                else if (sh_live >= NSLOT || sh_head >= NSLOT) r.status = ghsm_pkg::STS_FULL;
                else begin
                    slot = sh_head;
                    sh_head = sh_next[slot];
                    dp = sh_live;
                    sh_live++;
                    sh_alive[slot] = 1'b1;
                    sh_dpos[slot] = dp;
                    sh_next[slot] = NONE;
                    sh_dslot[dp] = slot;
                    sh_dmesh[dp] = mesh;
                    sh_dmat[dp] = mat;
                    r.ok = 1'b1;
                    r.hndl = {sh_gen[slot], 16'(slot + 1)};
                    r.dense = 10'(dp);
                    r.mesh = mesh;
                    r.mat = mat;
                end
            end
            ghsm_pkg::FN_DESTROY: begin
                if (!resolve_handle(h, slot, dp)) r.status = ghsm_pkg::STS_BAD_HNDL;
                else begin
                    last = sh_live - 1;
                    r.ok = 1'b1;
                    r.dense = 10'(dp);
                    r.mesh = sh_dmesh[dp];
                    r.mat = sh_dmat[dp];
                    if (dp != last) begin
                        moved = sh_dslot[last];
                        sh_dslot[dp] = moved;
                        sh_dpos[moved] = dp;
                        sh_dmesh[dp] = sh_dmesh[last];
                        sh_dmat[dp] = sh_dmat[last];
                    end
                    sh_live = last;
                    sh_alive[slot] = 1'b0;
                    sh_dpos[slot] = 0;
                    sh_gen[slot] = next_gen(sh_gen[slot]);
                    sh_next[slot] = sh_head;
                    sh_head = slot;
                end
            end
            ghsm_pkg::FN_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) sh_gen[i] = next_gen(sh_gen[i]);
                free_all();
                r.ok = 1'b1;
            end
            ghsm_pkg::FN_LOOKUP: begin
                if (!resolve_handle(h, slot, dp)) r.status = ghsm_pkg::STS_BAD_HNDL;
                else begin
                    r.ok = 1'b1;
                    r.hndl = h;
                    r.dense = 10'(dp);
                    r.mesh = sh_dmesh[dp];
                    r.mat = sh_dmat[dp];
                end
            end
            ghsm_pkg::FN_READ: begin
                if (pos >= sh_live) r.status = ghsm_pkg::STS_BAD_POS;
                else begin
                    slot = sh_dslot[pos];
                    r.ok = 1'b1;
                    r.hndl = {sh_gen[slot], 16'(slot + 1)};
                    r.dense = pos;
                    r.mesh = sh_dmesh[pos];
                    r.mat = sh_dmat[pos];
                end
            end
            default: ;
        endcase
        r.live = 11'(sh_live);
        return r;
    endfunction

    // Random idle length: mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(9) < 5) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    bit sender_gaps = 1'b1;

    // Offers one word, with valid low between words, and waits until it is
    // accepted; the prediction is made at acceptance.
    task automatic send_word(logic [2:0] fn, logic [31:0] h, logic [31:0] mesh,
                             logic [31:0] mat, logic [9:0] pos);
        slot_result_t r;
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        @(posedge aclk);
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {6'd0, pos, mat, mesh, h};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_op(fn, h, mesh, mat, pos);
        pending_results.push_back(r);
        if (fn == ghsm_pkg::FN_SPAWN && r.ok) known_handles.push_back(r.hndl);
        if (known_handles.size() > 300) void'(known_handles.pop_front());
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_handle();
        logic [31:0] h;
        if (known_handles.size() != 0 && $urandom_range(9) < 8)
            return known_handles[$urandom_range(known_handles.size() - 1)];
        h = $urandom();
        if ($urandom_range(1)) h[15:0] = 16'($urandom_range(1, 1030));
        return h;
    endfunction

    // Result checker: compares every accepted word with the oldest expectation.
    always @(posedge aclk) begin
        slot_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[120:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0d st=%0d h=%h d=%0d m=%h a=%h n=%0d, got ok=%0d st=%0d h=%h d=%0d m=%h a=%h n=%0d",
                                 want.ok, want.status, want.hndl, want.dense, want.mesh,
                                 want.mat, want.live, got.ok, got.status, got.hndl,
                                 got.dense, got.mesh, got.mat, got.live);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long forced hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(9) < 7);
    end

    task automatic long_hold(int cycles);
        stall_busy = 1'b1;
        hold_off = 1'b1;
        repeat (cycles) @(posedge aclk);
        hold_off = 1'b0;
        stall_busy = 1'b0;
    endtask

    // Extremes of every field, each operation and each failure case but a full map.
    task automatic test_directed();
        send_word(ghsm_pkg::FN_LOOKUP, 32'h0001_0000, 0, 0, 0);     // zero slot field
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'd0);                // read on empty map
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'd0, 32'h1234, 0);        // invalid mesh
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'h1, 32'h0, 0);
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 0);
        send_word(ghsm_pkg::FN_LOOKUP, 32'h0001_0001, 0, 0, 0);
        send_word(ghsm_pkg::FN_LOOKUP, 32'h0002_0001, 0, 0, 0);      // wrong generation
        send_word(ghsm_pkg::FN_LOOKUP, 32'h0001_0401, 0, 0, 0);      // slot out of range
        send_word(ghsm_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'd2);
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'd3);                // at live count
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'h3FF);
        send_word(ghsm_pkg::FN_DESTROY, 32'h0001_0001, 0, 0, 0);     // hole gets last record
        send_word(ghsm_pkg::FN_DESTROY, 32'h0001_0001, 0, 0, 0);     // now stale
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'd0);
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'h77, 32'h88, 0);         // reuses freed slot
        send_word(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_word(3'd6, 0, 0, 0, 0);
        send_word(3'd7, 0, 0, 0, 0);
        send_word(ghsm_pkg::FN_CLEAR, 0, 0, 0, 0);
        send_word(ghsm_pkg::FN_LOOKUP, 32'h0002_0002, 0, 0, 0);      // freed by clear
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'h9, 32'h9, 0);
        drain();
    endtask

    // Fill the whole map, hit the full case, clear it, then churn one slot through
    // repeated destroy and spawn.
    task automatic test_full_and_wrap();
        logic [31:0] h;
        for (int i = 0; i < NSLOT; i++)
            send_word(ghsm_pkg::FN_SPAWN, 0, $urandom() | 32'd1, $urandom(), 0);
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'h5, 32'h6, 0);
        send_word(ghsm_pkg::FN_SPAWN, 0, 32'h0, 32'h6, 0);
        send_word(ghsm_pkg::FN_READ, 0, 0, 0, 10'h3FF);
        send_word(ghsm_pkg::FN_CLEAR, 0, 0, 0, 0);
        drain();
        for (int i = 0; i < 5; i++) begin
            send_word(ghsm_pkg::FN_SPAWN, 0, 32'h3, 32'h4, 0);
            h = pending_results[$].hndl;
            send_word(ghsm_pkg::FN_DESTROY, h, 0, 0, 0);
        end
        drain();
    endtask

    // Mostly well-formed churn with random content, some noise.
    task automatic test_random(int n);
        int k;
        logic [2:0] fn;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 35) fn = ghsm_pkg::FN_SPAWN;
            else if (k < 60) fn = ghsm_pkg::FN_DESTROY;
            else if (k < 78) fn = ghsm_pkg::FN_LOOKUP;
            else if (k < 93) fn = ghsm_pkg::FN_READ;
            else if (k < 95) fn = ghsm_pkg::FN_CLEAR;
            else fn = 3'($urandom_range(5, 7));
            send_word(fn, pick_handle(), ($urandom_range(19) == 0) ? 32'd0 : rnd32() | 32'd1,
                      rnd32(), 10'($urandom_range(sh_live + 2)) ^ (($urandom_range(19) == 0)
                      ? 10'h3FF : 10'h0));
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full pause.
    task automatic test_backpressure();
        fork
            long_hold(400);
        join_none
        sender_gaps = 1'b0;
        test_random(25);
        sender_gaps = 1'b1;
        wait (!stall_busy);
        drain();
        test_random(15);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < NSLOT; i++) sh_gen[i] = 16'd1;
        free_all();
        test_directed();
        test_full_and_wrap();
        test_backpressure();
        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

endmodule
